// ===== hdl/elev_pkg.sv =====
`default_nettype none

package elev_pkg;

    typedef logic [1:0] floor_t;
    typedef logic [2:0] mask_t;
    typedef logic [7:0] ticks_t;

    localparam floor_t FLOOR_NONE   = 2'd0;
    localparam floor_t FLOOR_GROUND = 2'd1;
    localparam floor_t FLOOR_MID    = 2'd2;
    localparam floor_t FLOOR_TOP    = 2'd3;

    localparam ticks_t TICKS_RESET = 8'd15;

    // One time-base tick as it comes in.
    typedef struct packed {
        mask_t hall_up_calls;
        mask_t hall_down_calls;
        mask_t cabin_calls;
        mask_t obstacle_flags;
    } item_t;

    // One result beat.
    typedef struct packed {
        logic   motor_up;
        logic   motor_down;
        mask_t  floor_lamp;
        floor_t current_floor;
        logic   moving;
    } result_t;

    // One-hot lamp for a floor; dark for the unused code.
    function automatic mask_t lamp_of(input floor_t fl);
        mask_t lamp;
        begin
            case (fl)
                FLOOR_GROUND: lamp = 3'b001;
                FLOOR_MID:    lamp = 3'b010;
                FLOOR_TOP:    lamp = 3'b100;
                default:      lamp = 3'b000;
            endcase
            return lamp;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hdl/elev_core.sv =====
`default_nettype none

// Car state and the per-tick update: trip start, segment count, floor step.
module elev_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             advance,
    input  wire elev_pkg::item_t  item,
    input  wire elev_pkg::ticks_t ticks_per_floor,
    output elev_pkg::result_t     result
);

    elev_pkg::floor_t floor_reg,  floor_next;
    elev_pkg::floor_t target_reg, target_next;
    logic             active_reg, active_next;
    elev_pkg::ticks_t seg_reg,    seg_next;

    elev_pkg::mask_t  req;
    elev_pkg::mask_t  cand;
    elev_pkg::floor_t pick;
    elev_pkg::floor_t tgt;
    logic             blocked;
    logic             do_tick;
    logic             arrived;
    logic [8:0]       cnt;
    logic [8:0]       limit;

    always_comb
    begin
        req     = item.hall_up_calls | item.hall_down_calls | item.cabin_calls;
        blocked = (item.obstacle_flags != 3'b000);

        // lowest requested floor other than the current one
        cand = req & ~elev_pkg::lamp_of(floor_reg);
        if (cand[0])
            pick = elev_pkg::FLOOR_GROUND;
        else if (cand[1])
            pick = elev_pkg::FLOOR_MID;
        else if (cand[2])
            pick = elev_pkg::FLOOR_TOP;
        else
            pick = elev_pkg::FLOOR_NONE;

        tgt     = active_reg ? target_reg : pick;
        do_tick = !blocked && (active_reg || (pick != elev_pkg::FLOOR_NONE));

        // a fresh trip counts from zero
        cnt   = (active_reg ? {1'b0, seg_reg} : 9'd0) + 9'd1;
        limit = {1'b0, (ticks_per_floor == 8'd0) ? 8'd1 : ticks_per_floor};

        floor_next  = floor_reg;
        target_next = target_reg;
        active_next = active_reg;
        seg_next    = seg_reg;
        arrived     = 1'b0;

        if (do_tick)
        begin
            target_next = tgt;
            active_next = 1'b1;
            if (cnt >= limit)
            begin
                seg_next = 8'd0;
                if (tgt > floor_reg)
                    floor_next = floor_reg + 2'd1;
                else if (tgt < floor_reg)
                    floor_next = floor_reg - 2'd1;
                if (floor_next == tgt)
                begin
                    active_next = 1'b0;
                    arrived     = 1'b1;
                end
            end
            else
            begin
                seg_next = cnt[7:0];
            end
        end

        result.motor_up      = do_tick && !arrived && (tgt > floor_next);
        result.motor_down    = do_tick && !arrived && (tgt < floor_next);
        result.floor_lamp    = elev_pkg::lamp_of(floor_next);
        result.current_floor = floor_next;
        result.moving        = active_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            floor_reg  <= elev_pkg::FLOOR_GROUND;
            target_reg <= elev_pkg::FLOOR_GROUND;
            active_reg <= 1'b0;
            seg_reg    <= 8'd0;
        end
        else if (advance)
        begin
            floor_reg  <= floor_next;
            target_reg <= target_next;
            active_reg <= active_next;
            seg_reg    <= seg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/three_floor_elevator_controller.sv =====
`default_nettype none

// Channel  Dir  Handshake              Beat contents
// in       in   in_valid / in_ready    hall_up_calls, hall_down_calls,
//                                      cabin_calls, obstacle_flags
// out      out  out_valid / out_ready  motor_up, motor_down, floor_lamp,
//                                      current_floor, moving
// cfg      in   cfg_valid / cfg_ready  cfg_data -> ticks_per_floor
//
// One tick per clock while the output is not stalled: an input beat lands in
// the input register, the car update runs in one pass through elev_core and
// the result lands in the output register.
// Reset puts the car idle at the ground floor with ticks_per_floor = 15.
// A stalled output holds the output register; the input register keeps
// taking a beat while it is empty or its contents move on in the same cycle.
// cfg_ready is always high; write only while no tick is in flight.
module three_floor_elevator_controller (
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [2:0] hall_up_calls,
    input  wire logic [2:0] hall_down_calls,
    input  wire logic [2:0] cabin_calls,
    input  wire logic [2:0] obstacle_flags,

    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            motor_up,
    output logic            motor_down,
    output logic [2:0]      floor_lamp,
    output logic [1:0]      current_floor,
    output logic            moving,

    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    logic              in_vld_reg;
    elev_pkg::item_t   in_item_reg;
    logic              out_vld_reg;
    elev_pkg::result_t out_res_reg;
    elev_pkg::ticks_t  tpf_reg;

    elev_pkg::result_t step_res;
    logic              advance;

    // advance a tick from the input register into the output register
    assign advance   = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready  = !in_vld_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            tpf_reg     <= elev_pkg::TICKS_RESET;
        end
        else
        begin
            if (in_ready)
                in_vld_reg <= in_valid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (out_ready)
                out_vld_reg <= 1'b0;
            if (cfg_valid)
                tpf_reg <= cfg_data;
        end
    end

    // payload registers: hold unless a new beat moves in
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg.hall_up_calls   <= hall_up_calls;
            in_item_reg.hall_down_calls <= hall_down_calls;
            in_item_reg.cabin_calls     <= cabin_calls;
            in_item_reg.obstacle_flags  <= obstacle_flags;
        end
        if (advance)
            out_res_reg <= step_res;
    end

    elev_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .item            (in_item_reg),
        .ticks_per_floor (tpf_reg),
        .result          (step_res)
    );

    assign out_valid     = out_vld_reg;
    assign motor_up      = out_res_reg.motor_up;
    assign motor_down    = out_res_reg.motor_down;
    assign floor_lamp    = out_res_reg.floor_lamp;
    assign current_floor = out_res_reg.current_floor;
    assign moving        = out_res_reg.moving;

    // never drive both directions
    a_motor_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(motor_up && motor_down))
        else $error("motor driven up and down at once");

    // lamp follows the reported floor
    a_lamp_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (floor_lamp == elev_pkg::lamp_of(current_floor)))
        else $error("floor lamp disagrees with current floor");

    // motor only runs during a trip
    a_motor_trip: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (motor_up || motor_down)) |-> moving)
        else $error("motor running with no trip");

    // a result beat appears only after a tick has been taken
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) && !in_vld_reg |=> !out_valid)
        else $error("result beat without an input tick");

endmodule

`default_nettype wire

// ===== tb/sv/tb_three_floor_elevator_controller.sv =====
`timescale 1ns / 100ps

module tb_three_floor_elevator_controller;

    localparam int     IDLE_PERCENT = 37;
    localparam int     RESULT_LATENCY = 2;
    localparam realtime RUN_LIMIT = 10ms;

    logic   clk = 1'b0;
    logic   rst_n = 1'b0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    elev_pkg::mask_t  hall_up_calls = '0;
    elev_pkg::mask_t  hall_down_calls = '0;
    elev_pkg::mask_t  cabin_calls = '0;
    elev_pkg::mask_t  obstacle_flags = '0;

    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             motor_up;
    logic             motor_down;
    elev_pkg::mask_t  floor_lamp;
    elev_pkg::floor_t current_floor;
    logic             moving;

    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    elev_pkg::ticks_t cfg_data = '0;

    // Car model, advanced once per accepted tick beat.
    elev_pkg::ticks_t ticks_setting;
    elev_pkg::floor_t car_floor;
    elev_pkg::floor_t car_target;
    bit               car_travelling;
    elev_pkg::ticks_t car_segment;

    elev_pkg::result_t car_status_due[$];
    int                mismatch_count = 0;
    bit                steady_run = 1'b0;

    three_floor_elevator_controller dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .hall_up_calls   (hall_up_calls),
        .hall_down_calls (hall_down_calls),
        .cabin_calls     (cabin_calls),
        .obstacle_flags  (obstacle_flags),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .motor_up        (motor_up),
        .motor_down      (motor_down),
        .floor_lamp      (floor_lamp),
        .current_floor   (current_floor),
        .moving          (moving),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    always #10 clk = ~clk;

    // Stall the result side at random, except during a steady stretch.
    always @(negedge clk)
    begin
        out_ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // One clear tick of travel; returns 1 when the car reaches its target.
    // A zero setting behaves as one tick per floor.
    function automatic bit travel_one_tick();
        int needed;
        int count;
        needed = (ticks_setting == 0) ? 1 : int'(ticks_setting);
        count  = int'(car_segment) + 1;
        if (count >= needed)
        begin
            car_segment = '0;
            if (car_target > car_floor)
                car_floor = car_floor + 1'b1;
            else if (car_target < car_floor)
                car_floor = car_floor - 1'b1;
            if (car_floor == car_target)
            begin
                car_travelling = 1'b0;
                return 1'b1;
            end
        end
        else
        begin
            car_segment = elev_pkg::ticks_t'(count);
        end
        return 1'b0;
    endfunction

    // Advance the car by one tick beat and return the status it shows after.
    function automatic elev_pkg::result_t next_car_status(input elev_pkg::item_t tick);
        elev_pkg::mask_t   calls;
        bit                blocked;
        bit                drive;
        elev_pkg::floor_t  pick;
        elev_pkg::result_t status;
        calls   = tick.hall_up_calls | tick.hall_down_calls | tick.cabin_calls;
        blocked = |tick.obstacle_flags;
        drive   = 1'b0;
        pick    = elev_pkg::FLOOR_NONE;
        if (!car_travelling)
        begin
            // Idle: take the lowest called floor other than the one we are at;
            // the starting tick already counts as travel.
            if (!blocked)
            begin
                for (int fl = elev_pkg::FLOOR_GROUND; fl <= elev_pkg::FLOOR_TOP; fl++)
                begin
                    if (pick == elev_pkg::FLOOR_NONE && calls[fl - 1] &&
                        elev_pkg::floor_t'(fl) != car_floor)
                        pick = elev_pkg::floor_t'(fl);
                end
                if (pick != elev_pkg::FLOOR_NONE)
                begin
                    car_target     = pick;
                    car_travelling = 1'b1;
                    car_segment    = '0;
                    drive          = !travel_one_tick();
                end
            end
        end
        else if (!blocked)
        begin
            // Calls are ignored mid-trip; an obstacle holds the count.
            drive = !travel_one_tick();
        end
        status.motor_up      = drive && (car_target > car_floor);
        status.motor_down    = drive && (car_target < car_floor);
        status.floor_lamp    = elev_pkg::mask_t'(3'b001 << (car_floor - 1));
        status.current_floor = car_floor;
        status.moving        = car_travelling;
        return status;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Compare each result beat with the oldest status still due.
    always @(posedge clk)
    begin
        elev_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (car_status_due.size() == 0)
            begin
                $error("result beat with no status due");
                mismatch_count++;
            end
            else
            begin
                want = car_status_due.pop_front();
                check_field("motor_up", want.motor_up, motor_up);
                check_field("motor_down", want.motor_down, motor_down);
                check_field("floor_lamp", want.floor_lamp, floor_lamp);
                check_field("current_floor", want.current_floor, current_floor);
                check_field("moving", want.moving, moving);
            end
        end
    end

    // Offer one tick beat from a falling edge, hold it until taken,
    // and leave valid high for the next beat.
    task automatic send_tick(input elev_pkg::mask_t up_calls,
                             input elev_pkg::mask_t down_calls,
                             input elev_pkg::mask_t car_calls,
                             input elev_pkg::mask_t obstacles);
        elev_pkg::item_t tick;
        tick.hall_up_calls   = up_calls;
        tick.hall_down_calls = down_calls;
        tick.cabin_calls     = car_calls;
        tick.obstacle_flags  = obstacles;
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid        = 1'b1;
        hall_up_calls   = up_calls;
        hall_down_calls = down_calls;
        cabin_calls     = car_calls;
        obstacle_flags  = obstacles;
        do
            @(posedge clk);
        while (!in_ready);
        car_status_due.push_back(next_car_status(tick));
        @(negedge clk);
    endtask

    // Drain every result, let the pipeline settle, then write the register.
    task automatic write_ticks_per_floor(input elev_pkg::ticks_t value);
        in_valid = 1'b0;
        while (car_status_due.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        ticks_setting = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Idle car at the ground floor: empty calls, a call for the floor it is at,
    // obstacles that keep it parked, then a clear call that starts a trip.
    task automatic test_idle_requests();
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
        send_tick(3'b001, 3'b001, 3'b001, 3'b000);
        send_tick(3'b111, 3'b111, 3'b111, 3'b100);
        send_tick(3'b010, 3'b000, 3'b000, 3'b001);
        send_tick(3'b000, 3'b100, 3'b000, 3'b000);
    endtask

    // Mid-trip: each obstacle sensor stops the motor and holds the count,
    // and fresh calls are dropped.
    task automatic test_obstacle_in_trip();
        send_tick(3'b111, 3'b111, 3'b111, 3'b001);
        send_tick(3'b111, 3'b111, 3'b111, 3'b010);
        send_tick(3'b111, 3'b111, 3'b111, 3'b100);
        send_tick(3'b111, 3'b111, 3'b111, 3'b111);
        send_tick(3'b001, 3'b000, 3'b000, 3'b000);
        send_tick(3'b000, 3'b010, 3'b000, 3'b000);
        send_tick(3'b000, 3'b000, 3'b001, 3'b000);
    endtask

    // A zero setting passes one floor per clear tick, arrival included.
    task automatic test_zero_ticks();
        write_ticks_per_floor(8'd0);
        send_tick(3'b000, 3'b000, 3'b100, 3'b000);
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
        send_tick(3'b001, 3'b000, 3'b000, 3'b000);
        send_tick(3'b000, 3'b000, 3'b000, 3'b010);
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
    endtask

    // Fastest legal setting, walking the car up and back down.
    task automatic test_single_tick();
        write_ticks_per_floor(8'd1);
        send_tick(3'b000, 3'b010, 3'b000, 3'b000);
        send_tick(3'b100, 3'b000, 3'b000, 3'b000);
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
        send_tick(3'b000, 3'b000, 3'b011, 3'b000);
        send_tick(3'b000, 3'b000, 3'b000, 3'b000);
    endtask

    // Random traffic: mostly clear ticks with sparse calls, some blocked ticks.
    task automatic test_random_travel(input elev_pkg::ticks_t setting, input int beats,
                                      input bit steady);
        elev_pkg::mask_t up_calls;
        elev_pkg::mask_t down_calls;
        elev_pkg::mask_t car_calls;
        elev_pkg::mask_t obstacles;
        write_ticks_per_floor(setting);
        steady_run = steady;
        repeat (beats)
        begin
            up_calls   = ($urandom_range(99) < 30) ?
                         elev_pkg::mask_t'($urandom_range(7)) : '0;
            down_calls = ($urandom_range(99) < 30) ?
                         elev_pkg::mask_t'($urandom_range(7)) : '0;
            car_calls  = ($urandom_range(99) < 30) ?
                         elev_pkg::mask_t'($urandom_range(7)) : '0;
            obstacles  = ($urandom_range(99) < 15) ?
                         elev_pkg::mask_t'($urandom_range(1, 7)) : '0;
            send_tick(up_calls, down_calls, car_calls, obstacles);
        end
        steady_run = 1'b0;
    endtask

    initial
    begin
        // Model state after reset.
        ticks_setting  = elev_pkg::TICKS_RESET;
        car_floor      = elev_pkg::FLOOR_GROUND;
        car_target     = elev_pkg::FLOOR_GROUND;
        car_travelling = 1'b0;
        car_segment    = '0;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_idle_requests();
        test_obstacle_in_trip();
        test_zero_ticks();
        test_single_tick();

        test_random_travel(8'd2, 200, 1'b0);
        test_random_travel(8'd1, 150, 1'b1);
        test_random_travel(8'd0, 100, 1'b0);
        test_random_travel(8'd255, 550, 1'b0);
        test_random_travel(elev_pkg::ticks_t'($urandom_range(3, 9)), 200, 1'b0);

        // Drop valid, wait out every due status, then let the pipeline settle.
        in_valid = 1'b0;
        while (car_status_due.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 6) @(posedge clk);

        if (mismatch_count == 0)
            $display("tb_three_floor_elevator_controller: done, clean");
        else
            $display("tb_three_floor_elevator_controller: done, errors");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial
    begin
        #(RUN_LIMIT);
        $display("tb_three_floor_elevator_controller: done, errors");
        $finish;
    end

endmodule
